>>> hw/rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg: reaction time tester shared types
// Item and result layouts, operation, status and register codes.
// ----------------------------------------------------------------------------
package rtt_pkg;

	// operation codes of an input item
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// measurement status
	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_FALSE   = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_WAIT  = 3'd0;
	localparam logic [2:0] REG_WAIT_SPAN = 3'd1;
	localparam logic [2:0] REG_TIMEOUT   = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE  = 3'd3;
	localparam logic [2:0] REG_SETTLE    = 3'd4;

	// register reset values
	localparam logic [15:0] MIN_WAIT_RST  = 16'd1000;
	localparam logic [15:0] WAIT_SPAN_RST = 16'd2000;
	localparam logic [15:0] TIMEOUT_RST   = 16'd3000;
	localparam logic [7:0]  DEBOUNCE_RST  = 8'd20;
	localparam logic [9:0]  SETTLE_RST    = 10'd100;

	typedef struct packed {
		logic [1:0]  op;
		logic        button_down;
		logic [15:0] wait_offset;
		logic [3:0]  history_index;
	} req_t;

	typedef struct packed {
		logic        led_on;
		logic        busy_res;
		logic [1:0]  status;
		logic [15:0] reaction_ms;
		logic [4:0]  history_count;
		logic [15:0] history_value;
	} rsp_t;

endpackage

>>> hw/rtl/reaction_time_tester_top.sv
// ----------------------------------------------------------------------------
// reaction_time_tester_top: millisecond-tick reaction timer
// Runs one measurement per start transaction, reports status and reaction
// time, and keeps a history of ok results that drops its oldest entry.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_t (op, button, offset, index)
// rsp       out        rsp_valid/rsp_stall  rsp_t (led, busy, status, history)
// cfg       in         cfg_we               cfg_index, cfg_data
//
// One transaction per cycle unless req_stall is high; an accepted transaction is
// held in the input register, which feeds the result register and the history read.
// The state update and the history address are both done in the input stage.
// arst_n clears control state and loads the register defaults.
// rsp_stall holds the result register; req_stall rises only when the input
// stage holds a transaction that cannot move into a full, stalled result.
// ----------------------------------------------------------------------------
module reaction_time_tester_top
	import rtt_pkg::*;
#(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = ((AW > 4) ? AW : 4) + 1;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_RELEASE = 3'd1;
	localparam logic [2:0] PH_SETTLE  = 3'd2;
	localparam logic [2:0] PH_WAIT    = 3'd3;
	localparam logic [2:0] PH_LED     = 3'd4;

	// configuration
	logic [15:0] min_wait_q, wait_span_q, timeout_q;
	logic [7:0]  debounce_q;
	logic [9:0]  settle_q;

	// measurement state
	logic [2:0]  phase_q, phase_d;
	logic [15:0] timer_q, timer_d;
	logic [15:0] target_q, target_d;
	logic [7:0]  sle_q, sle_d;
	logic        bprev_q, bprev_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [AW-1:0] head_q, head_d;

	// pipeline
	logic        valid_s1;
	req_t        item_s1;
	logic        advance;
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	logic        hit_q;
	logic [15:0] rd_q;
	logic [15:0] hist_mem [HISTORY_DEPTH];

	// combinational results
	logic [1:0]  status_d;
	logic [15:0] reaction_d;
	logic        push;
	logic        hit_d;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [SW-1:0] wr_sum, rd_sum;
	logic [7:0]  sle_inc;
	logic        accepted;
	logic [16:0] tnext;
	logic [15:0] span, off;
	logic [16:0] wsum;
	logic [15:0] new_target;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_wait_q  <= MIN_WAIT_RST;
			wait_span_q <= WAIT_SPAN_RST;
			timeout_q   <= TIMEOUT_RST;
			debounce_q  <= DEBOUNCE_RST;
			settle_q    <= SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_WAIT:  min_wait_q  <= cfg_data;
				REG_WAIT_SPAN: wait_span_q <= cfg_data;
				REG_TIMEOUT:   timeout_q   <= cfg_data;
				REG_DEBOUNCE:  debounce_q  <= cfg_data[7:0];
				REG_SETTLE:    settle_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// wait length for a start: offset saturates below the span, sum at 16 bits
	always_comb begin
		span = (wait_span_q == 16'd0) ? 16'd1 : wait_span_q;
		off  = (item_s1.wait_offset >= span) ? span - 16'd1 : item_s1.wait_offset;
		wsum = {1'b0, min_wait_q} + {1'b0, off};
		new_target = wsum[16] ? 16'hFFFF : wsum[15:0];
	end

	// history addresses: one compare and subtract wraps the ring
	always_comb begin
		wr_sum = SW'(head_q) + SW'(fill_q);
		if (wr_sum >= SW'(HISTORY_DEPTH))
			wr_sum = wr_sum - SW'(HISTORY_DEPTH);
		rd_sum = SW'(head_q) + SW'(item_s1.history_index);
		if (rd_sum >= SW'(HISTORY_DEPTH))
			rd_sum = rd_sum - SW'(HISTORY_DEPTH);
		wr_addr = (fill_q == FW'(HISTORY_DEPTH)) ? head_q : wr_sum[AW-1:0];
		rd_addr = rd_sum[AW-1:0];
	end

	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		target_d   = target_q;
		sle_d      = sle_q;
		bprev_d    = bprev_q;
		fill_d     = fill_q;
		head_d     = head_q;
		status_d   = ST_NONE;
		reaction_d = 16'd0;
		push       = 1'b0;
		hit_d      = 1'b0;
		sle_inc    = (sle_q == 8'hFF) ? sle_q : sle_q + 8'd1;
		accepted   = 1'b0;
		tnext      = {1'b0, timer_q} + 17'd1;

		unique case (item_s1.op)
			OP_TICK: begin
				accepted = item_s1.button_down && !bprev_q && sle_inc >= debounce_q &&
					(phase_q == PH_WAIT || phase_q == PH_LED);
				sle_d   = accepted ? 8'd0 : sle_inc;
				bprev_d = item_s1.button_down;
				unique case (phase_q)
					PH_RELEASE: begin
						if (item_s1.button_down) begin
							if (timer_q >= timeout_q) begin
								status_d = ST_FALSE;
								phase_d  = PH_IDLE;
								timer_d  = 16'd0;
							end else begin
								timer_d = tnext[15:0];
							end
						end else begin
							timer_d = 16'd0;
							if (settle_q != 10'd0)
								phase_d = PH_SETTLE;
							else
								phase_d = (target_q == 16'd0) ? PH_LED : PH_WAIT;
						end
					end
					PH_SETTLE: begin
						if (tnext >= 17'(settle_q)) begin
							timer_d = 16'd0;
							phase_d = (target_q == 16'd0) ? PH_LED : PH_WAIT;
						end else begin
							timer_d = tnext[15:0];
						end
					end
					PH_WAIT: begin
						if (item_s1.button_down) begin
							status_d = ST_FALSE;
							phase_d  = PH_IDLE;
							timer_d  = 16'd0;
						end else if (tnext >= {1'b0, target_q}) begin
							phase_d = PH_LED;
							timer_d = 16'd0;
						end else begin
							timer_d = tnext[15:0];
						end
					end
					PH_LED: begin
						if (accepted) begin
							reaction_d = tnext[16] ? 16'hFFFF : tnext[15:0];
							status_d   = ST_OK;
							push       = 1'b1;
							phase_d    = PH_IDLE;
							timer_d    = 16'd0;
							// full ring: overwrite the oldest and advance past it
							if (fill_q == FW'(HISTORY_DEPTH))
								head_d = (head_q == AW'(HISTORY_DEPTH - 1)) ?
									'0 : head_q + AW'(1);
							else
								fill_d = fill_q + FW'(1);
						end else if (tnext > {1'b0, timeout_q}) begin
							status_d = ST_TIMEOUT;
							phase_d  = PH_IDLE;
							timer_d  = 16'd0;
						end else begin
							timer_d = tnext[15:0];
						end
					end
					default: ;
				endcase
			end
			OP_START: begin
				if (phase_q == PH_IDLE) begin
					target_d = new_target;
					timer_d  = 16'd0;
					if (bprev_q)
						phase_d = PH_RELEASE;
					else
						phase_d = (new_target == 16'd0) ? PH_LED : PH_WAIT;
				end
			end
			OP_READ: hit_d = SW'(item_s1.history_index) < SW'(fill_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			timer_q     <= 16'd0;
			target_q    <= 16'd0;
			sle_q       <= 8'hFF;
			bprev_q     <= 1'b0;
			fill_q      <= '0;
			head_q      <= '0;
			hit_q       <= 1'b0;
		end else begin
			if (!req_stall)
				valid_s1 <= req_valid;
			if (advance) begin
				rsp_valid_q <= 1'b1;
				phase_q     <= phase_d;
				timer_q     <= timer_d;
				target_q    <= target_d;
				sle_q       <= sle_d;
				bprev_q     <= bprev_d;
				fill_q      <= fill_d;
				head_q      <= head_d;
				hit_q       <= hit_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			item_s1 <= req;
		if (advance) begin
			rsp_q.led_on        <= (phase_d == PH_LED);
			rsp_q.busy_res      <= (phase_d != PH_IDLE);
			rsp_q.status        <= status_d;
			rsp_q.reaction_ms   <= reaction_d;
			rsp_q.history_count <= 5'(fill_d);
			rsp_q.history_value <= 16'd0;
		end
	end

	// history ring: write on an ok result, registered read for read transactions
	always_ff @(posedge clk) begin
		if (advance && push)
			hist_mem[wr_addr] <= reaction_d;
		if (advance)
			rd_q <= hist_mem[rd_addr];
	end

	assign rsp_valid = rsp_valid_q;
	always_comb begin
		rsp = rsp_q;
		rsp.history_value = hit_q ? rd_q : 16'd0;
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(HISTORY_DEPTH))
		else $error("history fill beyond depth");

	a_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != FW'(HISTORY_DEPTH) |-> head_q == '0)
		else $error("history head moved before the ring filled");

	a_ok_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ST_OK |->
			!rsp_q.busy_res && !rsp_q.led_on && rsp_q.reaction_ms != 16'd0)
		else $error("ok result without a finished measurement");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a held transaction");
`endif

endmodule
